// ===== rtl/wavhp_pkg.sv =====
// Package for the WAV header parser: field widths, status codes, tags,
// register indexes and the shared structs. No dependencies.
package wavhp_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int HALF_W   = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;
    localparam int POS_W    = 5;   // longest fixed run is the 16-byte fmt body
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_PARSING   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HEADER_OK = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_RIFF  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FMT_SHORT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_PCM   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LIMIT  = 1'd1;

    localparam logic [WORD_W-1:0]  STREAM_LIMIT_RESET = 32'd4194304;
    localparam logic [COUNT_W-1:0] CHUNK_LIMIT_RESET  = 8'd8;

    localparam logic [WORD_W-1:0] TAG_FMT  = 32'h666D_7420;  // "fmt "
    localparam logic [WORD_W-1:0] TAG_DATA = 32'h6461_7461;  // "data"
    localparam logic [HALF_W-1:0] FORMAT_PCM = 16'd1;
    localparam logic [WORD_W-1:0] FMT_MIN_SIZE = 32'd16;

    typedef struct packed {
        logic [WORD_W-1:0]  stream_limit;
        logic [COUNT_W-1:0] chunk_limit;
    } wavhp_cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   rate_hz;
        logic [HALF_W-1:0]   channel_count;
        logic [HALF_W-1:0]   depth_bits;
        logic [WORD_W-1:0]   data_bytes;
    } wavhp_result_t;

endpackage

// ===== rtl/wavhp_in_if.sv =====
// Byte stream channel: valid/ready handshake plus one stream byte.
// Depends on wavhp_pkg.
interface wavhp_in_if import wavhp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              restart;

    modport source (output valid, output byte_value, output restart, input ready);
    modport sink   (input valid, input byte_value, input restart, output ready);
endinterface

// ===== rtl/wavhp_out_if.sv =====
// Result channel: valid/ready handshake plus status and format fields.
// Depends on wavhp_pkg.
interface wavhp_out_if import wavhp_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   rate_hz;
    logic [HALF_W-1:0]   channel_count;
    logic [HALF_W-1:0]   depth_bits;
    logic [WORD_W-1:0]   data_bytes;

    modport source (output valid, output status, output rate_hz,
                    output channel_count, output depth_bits,
                    output data_bytes, input ready);
    modport sink   (input valid, input status, input rate_hz,
                    input channel_count, input depth_bits,
                    input data_bytes, output ready);
endinterface

// ===== rtl/wavhp_cfg.sv =====
// Configuration registers: streaming size limit and chunk limit.
// Depends on wavhp_pkg.
module wavhp_cfg import wavhp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  write_en,
    input  logic [CFG_IDX_W-1:0]  index,
    input  logic [CFG_DATA_W-1:0] data,
    output wavhp_cfg_t            cfg
);

    logic [WORD_W-1:0]  stream_limit_reg;
    logic [COUNT_W-1:0] chunk_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_limit_reg <= STREAM_LIMIT_RESET;
            chunk_limit_reg  <= CHUNK_LIMIT_RESET;
        end
        else if (write_en)
        begin
            case (index)
                REG_STREAM_LIMIT: stream_limit_reg <= data[WORD_W-1:0];
                REG_CHUNK_LIMIT:  chunk_limit_reg  <= data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.stream_limit = stream_limit_reg;
    assign cfg.chunk_limit  = chunk_limit_reg;

endmodule

// ===== rtl/wavhp_core.sv =====
// Parse state and its one-byte update; presents the post-update fields.
// Depends on wavhp_pkg.
module wavhp_core import wavhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              restart,
    input  wavhp_cfg_t        cfg,
    output wavhp_result_t     result
);

    typedef enum logic [2:0] {
        PH_RIFF, PH_HDR, PH_FMT, PH_SKIP_EVEN, PH_SKIP_ODD, PH_PAD, PH_DONE
    } phase_t;

    phase_t              phase_reg, phase_next, c_phase;
    logic [POS_W-1:0]    pos_reg, pos_next, c_pos;
    logic [WORD_W-1:0]   tag_reg, tag_next, c_tag;
    logic [WORD_W-1:0]   size_reg, size_next, c_size;
    logic [COUNT_W-1:0]  seen_reg, seen_next, c_seen;
    logic [HALF_W-1:0]   fmt_reg, fmt_next, c_fmt;
    logic [WORD_W-1:0]   rate_reg, rate_next, c_rate;
    logic [HALF_W-1:0]   chan_reg, chan_next, c_chan;
    logic [HALF_W-1:0]   depth_reg, depth_next, c_depth;
    logic [WORD_W-1:0]   len_reg, len_next, c_len;
    logic [STATUS_W-1:0] status_reg, status_next, c_status;

    logic [WORD_W-1:0]  tag_hdr, size_hdr, size_dec;
    logic [COUNT_W-1:0] seen_inc, seen_chk;
    logic               do_next, skip_req, skip_odd, riff_chk;
    logic [WORD_W-1:0]  skip_count;
    logic [BYTE_W-1:0]  riff_exp;

    // Expected header byte; middle four (RIFF size) are not checked
    always_comb
    begin
        riff_chk = 1'b1;
        riff_exp = 8'h00;
        case (c_pos)
            5'd0:  riff_exp = 8'h52;  // R
            5'd1:  riff_exp = 8'h49;  // I
            5'd2:  riff_exp = 8'h46;  // F
            5'd3:  riff_exp = 8'h46;  // F
            5'd8:  riff_exp = 8'h57;  // W
            5'd9:  riff_exp = 8'h41;  // A
            5'd10: riff_exp = 8'h56;  // V
            5'd11: riff_exp = 8'h45;  // E
            default: riff_chk = 1'b0;
        endcase
    end

    always_comb
    begin
        // restart clears parse state ahead of this byte
        c_phase  = restart ? PH_RIFF : phase_reg;
        c_pos    = restart ? '0 : pos_reg;
        c_tag    = restart ? '0 : tag_reg;
        c_size   = restart ? '0 : size_reg;
        c_seen   = restart ? '0 : seen_reg;
        c_fmt    = restart ? '0 : fmt_reg;
        c_rate   = restart ? '0 : rate_reg;
        c_chan   = restart ? '0 : chan_reg;
        c_depth  = restart ? '0 : depth_reg;
        c_len    = restart ? '0 : len_reg;
        c_status = restart ? ST_PARSING : status_reg;

        phase_next  = c_phase;
        pos_next    = c_pos;
        tag_next    = c_tag;
        size_next   = c_size;
        seen_next   = c_seen;
        fmt_next    = c_fmt;
        rate_next   = c_rate;
        chan_next   = c_chan;
        depth_next  = c_depth;
        len_next    = c_len;
        status_next = c_status;

        seen_inc = (c_seen == {COUNT_W{1'b1}}) ? c_seen : c_seen + 8'd1;
        seen_chk = c_seen;
        do_next  = 1'b0;
        skip_req = 1'b0;
        skip_odd = 1'b0;
        skip_count = '0;
        size_dec = c_size - 32'd1;

        tag_hdr  = (c_pos < 5'd4) ? {c_tag[WORD_W-BYTE_W-1:0], byte_value} : c_tag;
        size_hdr = c_size;
        if (c_pos >= 5'd4)
            size_hdr[{c_pos[1:0], 3'b000} +: BYTE_W] = byte_value;

        case (c_phase)
            PH_RIFF:
            begin
                if (riff_chk && byte_value != riff_exp)
                begin
                    status_next = ST_BAD_RIFF;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    pos_next = c_pos + 5'd1;
                    if (c_pos == 5'd11)
                        do_next = 1'b1;
                end
            end
            PH_HDR:
            begin
                tag_next  = tag_hdr;
                size_next = size_hdr;
                pos_next  = c_pos + 5'd1;
                if (c_pos == 5'd7)
                begin
                    if (tag_hdr == TAG_FMT)
                    begin
                        if (size_hdr < FMT_MIN_SIZE)
                        begin
                            status_next = ST_FMT_SHORT;
                            phase_next  = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_FMT;
                            pos_next   = '0;
                        end
                    end
                    else if (tag_hdr == TAG_DATA)
                    begin
                        len_next    = (size_hdr > cfg.stream_limit) ? '0 : size_hdr;
                        status_next = ST_HEADER_OK;
                        phase_next  = PH_DONE;
                    end
                    else
                    begin
                        skip_req   = 1'b1;
                        skip_count = size_hdr;
                        skip_odd   = size_hdr[0];
                    end
                end
            end
            PH_FMT:
            begin
                pos_next = c_pos + 5'd1;
                if (c_pos < 5'd2)
                    fmt_next[{c_pos[0], 3'b000} +: BYTE_W] = byte_value;
                else if (c_pos < 5'd4)
                    chan_next[{c_pos[0], 3'b000} +: BYTE_W] = byte_value;
                else if (c_pos < 5'd8)
                    rate_next[{c_pos[1:0], 3'b000} +: BYTE_W] = byte_value;
                else if (c_pos >= 5'd14)
                    depth_next[{c_pos[0], 3'b000} +: BYTE_W] = byte_value;

                if (c_pos == 5'd1 && {byte_value, c_fmt[BYTE_W-1:0]} != FORMAT_PCM)
                begin
                    status_next = ST_NOT_PCM;
                    phase_next  = PH_DONE;
                    pos_next    = c_pos;
                end
                else if (c_pos == 5'd15)
                begin
                    // extension bytes beyond the 16-byte body are skipped
                    skip_req   = 1'b1;
                    skip_count = c_size - FMT_MIN_SIZE;
                    skip_odd   = c_size[0];
                end
            end
            PH_SKIP_EVEN, PH_SKIP_ODD:
            begin
                size_next = size_dec;
                if (size_dec == '0)
                begin
                    if (c_phase == PH_SKIP_ODD)
                        phase_next = PH_PAD;
                    else
                    begin
                        do_next   = 1'b1;
                        seen_next = seen_inc;
                        seen_chk  = seen_inc;
                    end
                end
            end
            PH_PAD:
            begin
                do_next   = 1'b1;
                seen_next = seen_inc;
                seen_chk  = seen_inc;
            end
            default: ;
        endcase

        if (skip_req)
        begin
            if (skip_count == '0)
            begin
                do_next   = 1'b1;
                seen_next = seen_inc;
                seen_chk  = seen_inc;
            end
            else
            begin
                size_next  = skip_count;
                phase_next = skip_odd ? PH_SKIP_ODD : PH_SKIP_EVEN;
            end
        end

        if (do_next)
        begin
            if (seen_chk >= cfg.chunk_limit)
            begin
                status_next = ST_TOO_MANY;
                phase_next  = PH_DONE;
            end
            else
            begin
                phase_next = PH_HDR;
                pos_next   = '0;
                tag_next   = '0;
                size_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            pos_reg    <= '0;
            tag_reg    <= '0;
            size_reg   <= '0;
            seen_reg   <= '0;
            fmt_reg    <= '0;
            rate_reg   <= '0;
            chan_reg   <= '0;
            depth_reg  <= '0;
            len_reg    <= '0;
            status_reg <= ST_PARSING;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            tag_reg    <= tag_next;
            size_reg   <= size_next;
            seen_reg   <= seen_next;
            fmt_reg    <= fmt_next;
            rate_reg   <= rate_next;
            chan_reg   <= chan_next;
            depth_reg  <= depth_next;
            len_reg    <= len_next;
            status_reg <= status_next;
        end
    end

    assign result.status        = status_next;
    assign result.rate_hz       = rate_next;
    assign result.channel_count = chan_next;
    assign result.depth_bits    = depth_next;
    assign result.data_bytes    = len_next;

endmodule

// ===== rtl/wav_header_parser_top.sv =====
// WAV header parser top: input register, parse core, result register.
// An accepted stream beat passes the input register, then the result register;
// one beat per cycle sustained while the result side does not stall.
// Async active-low reset clears parse state, empties both register stages and
// loads the configuration defaults (limit 4194304 bytes, 8 chunks).
// Depends on wavhp_pkg, wavhp_in_if, wavhp_out_if, wavhp_cfg, wavhp_core.
module wav_header_parser_top import wavhp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    wavhp_in_if.sink              stream,
    wavhp_out_if.source           result,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Stage 1: registered input beat
    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_restart_reg;

    // Stage 2: registered result beat
    logic          out_valid_reg, out_valid_next;
    wavhp_result_t out_data_reg;

    wavhp_cfg_t    cfg;
    wavhp_result_t core_result;

    logic out_free;   // result register can take a new beat this cycle
    logic step;       // stage 1 beat moves through the parser
    logic take;       // stream beat accepted

    wavhp_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (cfg_write_en),
        .index    (cfg_index),
        .data     (cfg_data),
        .cfg      (cfg)
    );

    // Parse state advances only when the beat leaves stage 1
    wavhp_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_value (s1_byte_reg),
        .restart    (s1_restart_reg),
        .cfg        (cfg),
        .result     (core_result)
    );

    assign out_free     = !out_valid_reg || result.ready;
    assign step         = s1_valid_reg && out_free;
    assign stream.ready = !s1_valid_reg || out_free;
    assign take         = stream.valid && stream.ready;

    // Stage 1 refills in the same cycle it drains
    assign s1_valid_next  = take ? 1'b1 : (step ? 1'b0 : s1_valid_reg);
    assign out_valid_next = step ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_byte_reg    <= stream.byte_value;
            s1_restart_reg <= stream.restart;
        end
        if (step)
            out_data_reg <= core_result;
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_data_reg.status;
    assign result.rate_hz       = out_data_reg.rate_hz;
    assign result.channel_count = out_data_reg.channel_count;
    assign result.depth_bits    = out_data_reg.depth_bits;
    assign result.data_bytes    = out_data_reg.data_bytes;

endmodule

// ===== rtl/wavhp_checker.sv =====
// Port-level checks for wav_header_parser_top, attached by bind.
// Depends on wavhp_pkg, wavhp_in_if, wavhp_out_if.
module wavhp_checker import wavhp_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    wavhp_in_if.sink    stream,
    wavhp_out_if.source result
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid)
        else $error("result beat dropped while stalled");

    // a new result beat needs an accepted stream beat ahead of it, through stage 1
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(stream.valid && stream.ready, 2))
        else $error("result beat without a matching stream beat");

    // a data length is only reported with a good header
    a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data_bytes != '0 |-> result.status == ST_HEADER_OK)
        else $error("data length without header ok status");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.status <= ST_TOO_MANY)
        else $error("undefined status code");

endmodule

bind wav_header_parser_top wavhp_checker u_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .stream (stream),
    .result (result)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for wav_header_parser_top: feeds WAV byte streams,
// predicts each result beat and compares it. Depends on wavhp_pkg and the RTL.
module tb;
    import wavhp_pkg::*;

    typedef logic [BYTE_W-1:0] octet_t;

    // Parse position of the byte-level predictor
    typedef enum logic [2:0] {
        WALK_RIFF,
        WALK_HEADER,
        WALK_FMT,
        WALK_SKIP_EVEN,
        WALK_SKIP_ODD,
        WALK_PAD,
        WALK_DONE
    } walk_t;

    // "RIFF", four unchecked size bytes, "WAVE"
    localparam logic [95:0] RIFF_PATTERN = {"RIFF", 32'h0, "WAVE"};

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wavhp_in_if  stream_ch ();
    wavhp_out_if result_ch ();

    wav_header_parser_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream       (stream_ch),
        .result       (result_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // Predicted result beats, oldest first; one per accepted stream beat
    wavhp_result_t predicted_reports[$];
    int unsigned   mismatches = 0;
    int unsigned   bytes_sent = 0;
    logic          quiet_link = 1'b0;    // no idling on either side while set
    int unsigned   stall_left = 0;
    octet_t        wav_bytes[$];         // stream under construction

    // Predictor copy of the configuration registers
    logic [WORD_W-1:0]  lim_bytes;
    logic [COUNT_W-1:0] lim_chunks;

    // Predictor copy of the parse state
    walk_t               walk;
    int unsigned         walk_pos;
    logic [WORD_W-1:0]   walk_tag;
    logic [WORD_W-1:0]   walk_size;
    logic [COUNT_W-1:0]  chunks_done;
    logic [HALF_W-1:0]   fmt_code;
    logic [HALF_W-1:0]   chan_r;
    logic [HALF_W-1:0]   depth_r;
    logic [WORD_W-1:0]   rate_r;
    logic [WORD_W-1:0]   length_r;
    logic [STATUS_W-1:0] status_r;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_walk();
        walk        = WALK_RIFF;
        walk_pos    = 0;
        walk_tag    = '0;
        walk_size   = '0;
        chunks_done = '0;
        fmt_code    = '0;
        chan_r      = '0;
        depth_r     = '0;
        rate_r      = '0;
        length_r    = '0;
        status_r    = ST_PARSING;
    endfunction

    // Terminal status: held until a restart
    function automatic void end_walk(input logic [STATUS_W-1:0] code);
        status_r = code;
        walk     = WALK_DONE;
    endfunction

    // Chunk limit is checked before every chunk header, the first one too
    function automatic void open_chunk();
        if (chunks_done >= lim_chunks)
            end_walk(ST_TOO_MANY);
        else
        begin
            walk      = WALK_HEADER;
            walk_pos  = 0;
            walk_tag  = '0;
            walk_size = '0;
        end
    endfunction

    function automatic void close_chunk();
        if (chunks_done != 8'd255)
            chunks_done = chunks_done + 1'b1;
        open_chunk();
    endfunction

    function automatic void enter_skip(input logic [WORD_W-1:0] count, input logic odd);
        if (count == 0)
            close_chunk();
        else
        begin
            walk_size = count;
            if (odd)
                walk = WALK_SKIP_ODD;
            else
                walk = WALK_SKIP_EVEN;
        end
    endfunction

    function automatic wavhp_result_t walk_wav_byte(input octet_t b, input logic rs);
        wavhp_result_t r;
        int unsigned   p;
        if (rs)
            clear_walk();
        p = walk_pos;
        case (walk)
            WALK_RIFF:
            begin
                // bytes 4..7 carry the RIFF size and are not checked
                if ((p < 4 || p >= 8) && p < 12 && b != RIFF_PATTERN[95 - 8*p -: 8])
                    end_walk(ST_BAD_RIFF);
                else
                begin
                    walk_pos = p + 1;
                    if (walk_pos >= 12)
                        open_chunk();
                end
            end
            WALK_HEADER:
            begin
                if (p < 4)
                    walk_tag = {walk_tag[23:0], b};
                else if (p < 8)
                    walk_size[8*(p-4) +: 8] = b;
                walk_pos = p + 1;
                if (walk_pos >= 8)
                begin
                    if (walk_tag == TAG_FMT)
                    begin
                        if (walk_size < FMT_MIN_SIZE)
                            end_walk(ST_FMT_SHORT);
                        else
                        begin
                            walk     = WALK_FMT;
                            walk_pos = 0;
                        end
                    end
                    else if (walk_tag == TAG_DATA)
                    begin
                        length_r = (walk_size > lim_bytes) ? '0 : walk_size;
                        end_walk(ST_HEADER_OK);
                    end
                    else
                        enter_skip(walk_size, walk_size[0]);
                end
            end
            WALK_FMT:
            begin
                if (p < 2)
                    fmt_code[8*p +: 8] = b;
                else if (p < 4)
                    chan_r[8*(p-2) +: 8] = b;
                else if (p < 8)
                    rate_r[8*(p-4) +: 8] = b;
                else if (p >= 14 && p < 16)
                    depth_r[8*(p-14) +: 8] = b;
                // format code is judged once both of its bytes are in
                if (p == 1 && fmt_code != FORMAT_PCM)
                    end_walk(ST_NOT_PCM);
                else
                begin
                    walk_pos = p + 1;
                    if (walk_pos >= 16)
                        enter_skip(walk_size - FMT_MIN_SIZE, walk_size[0]);
                end
            end
            WALK_SKIP_EVEN, WALK_SKIP_ODD:
            begin
                walk_size = walk_size - 1'b1;
                if (walk_size == 0)
                begin
                    if (walk == WALK_SKIP_ODD)
                        walk = WALK_PAD;
                    else
                        close_chunk();
                end
            end
            WALK_PAD:
                close_chunk();
            default: ;
        endcase
        r.status        = status_r;
        r.rate_hz       = rate_r;
        r.channel_count = chan_r;
        r.depth_bits    = depth_r;
        r.data_bytes    = length_r;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idling: mostly none, some short gaps, now and then a long one
    // ------------------------------------------------------------------
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_link || r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    // Result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            stall_left      <= idle_length();
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted beat against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        wavhp_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (predicted_reports.size() == 0)
            begin
                $display("%0t ns: result beat with no prediction pending", $time);
                mismatches++;
            end
            else
            begin
                want = predicted_reports.pop_front();
                check_field("status", WORD_W'(want.status), WORD_W'(result_ch.status));
                check_field("rate_hz", want.rate_hz, result_ch.rate_hz);
                check_field("channel_count", WORD_W'(want.channel_count),
                            WORD_W'(result_ch.channel_count));
                check_field("depth_bits", WORD_W'(want.depth_bits),
                            WORD_W'(result_ch.depth_bits));
                check_field("data_bytes", want.data_bytes, result_ch.data_bytes);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stream side
    // ------------------------------------------------------------------
    // One beat; valid stays high into the next call unless a gap is drawn,
    // so valid never sees two assignments in one step.
    task automatic send_byte(input octet_t b, input logic rs);
        int unsigned gap;
        stream_ch.byte_value <= b;
        stream_ch.restart    <= rs;
        stream_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        predicted_reports.push_back(walk_wav_byte(b, rs));
        bytes_sent++;
        gap = idle_length();
        if (gap != 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_stream(input logic restart_first);
        quiet_link <= ($urandom_range(0, 4) == 0);
        foreach (wav_bytes[i])
            send_byte(wav_bytes[i], restart_first && i == 0);
        wav_bytes.delete();
    endtask

    // Stop sending and wait for every predicted beat to come back
    task automatic drain_results();
        stream_ch.valid <= 1'b0;
        while (predicted_reports.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers; only called once the parser is drained
    task automatic set_limits(input logic [WORD_W-1:0] bytes_max,
                              input logic [COUNT_W-1:0] chunks_max);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_STREAM_LIMIT;
        cfg_data     <= bytes_max;
        @(posedge clk);
        cfg_index    <= REG_CHUNK_LIMIT;
        cfg_data     <= CFG_DATA_W'(chunks_max);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        lim_bytes  = bytes_max;
        lim_chunks = chunks_max;
    endtask

    // ------------------------------------------------------------------
    // Stream builders (little-endian sizes, tags first byte first)
    // ------------------------------------------------------------------
    function automatic void add_le(input logic [WORD_W-1:0] v, input int n);
        for (int i = 0; i < n; i++)
            wav_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void add_tag(input logic [WORD_W-1:0] t);
        for (int i = 3; i >= 0; i--)
            wav_bytes.push_back(t[8*i +: 8]);
    endfunction

    // bad_at < 0 gives a clean header, else that byte is spoilt
    function automatic void add_riff(input int bad_at);
        octet_t spoil;
        add_tag("RIFF");
        add_le($urandom, 4);
        add_tag("WAVE");
        if (bad_at >= 0)
        begin
            spoil = octet_t'($urandom_range(1, 255));
            wav_bytes[wav_bytes.size() - 12 + bad_at] ^= spoil;
        end
    endfunction

    function automatic void add_fmt(input logic [WORD_W-1:0] size, input logic [HALF_W-1:0] code,
                                    input logic [HALF_W-1:0] chans,
                                    input logic [WORD_W-1:0] rate,
                                    input logic [HALF_W-1:0] depth);
        add_tag(TAG_FMT);
        add_le(size, 4);
        if (size >= FMT_MIN_SIZE)
        begin
            add_le(WORD_W'(code), 2);
            add_le(WORD_W'(chans), 2);
            add_le(rate, 4);
            add_le($urandom, 4);     // byte rate, not taken
            add_le($urandom, 2);     // block align, not taken
            add_le(WORD_W'(depth), 2);
            for (int i = 16; i < size; i++)
                add_le($urandom, 1);
            if (size[0])
                add_le($urandom, 1);
        end
    endfunction

    // Unknown chunk; some tags share three bytes with fmt or data
    function automatic void add_junk(input logic [WORD_W-1:0] size);
        int unsigned r;
        octet_t      last;
        r    = $urandom_range(0, 99);
        last = octet_t'($urandom);
        if (r < 15)
            add_tag({TAG_FMT[31:8], (last == TAG_FMT[7:0]) ? ~last : last});
        else if (r < 30)
            add_tag({TAG_DATA[31:8], (last == TAG_DATA[7:0]) ? ~last : last});
        else
            add_tag($urandom);
        add_le(size, 4);
        for (int i = 0; i < size; i++)
            add_le($urandom, 1);
        if (size[0])
            add_le($urandom, 1);
    endfunction

    function automatic void add_data(input logic [WORD_W-1:0] size);
        add_tag(TAG_DATA);
        add_le(size, 4);
    endfunction

    function automatic logic [WORD_W-1:0] junk_size();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [WORD_W-1:0] fmt_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return FMT_MIN_SIZE;
        if (r < 92)
            return $urandom_range(17, 24);
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [HALF_W-1:0] fmt_code_pick();
        case ($urandom_range(0, 19))
            0:       return 16'h0003;
            1:       return 16'h0101;     // low byte right, high byte wrong
            default: return FORMAT_PCM;
        endcase
    endfunction

    // Data sizes cluster round the current limit to hit the boundary
    function automatic logic [WORD_W-1:0] data_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 5000);
        if (r < 65)
            return $urandom;
        if (r < 75)
            return lim_bytes;
        if (r < 85)
            return lim_bytes + 1;
        if (r < 90)
            return lim_bytes - 1;
        if (r < 95)
            return '0;
        return '1;
    endfunction

    // One random stream: mostly well-formed headers with random content,
    // some spoilt tags, cut-off streams and plain noise
    task automatic random_wav();
        int unsigned r;
        int unsigned cut;
        int          bad;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            repeat ($urandom_range(4, 24))
                add_le($urandom, 1);
        end
        else
        begin
            bad = $urandom_range(0, 7);
            if (bad >= 4)
                bad += 4;
            add_riff((r < 10) ? bad : -1);
            repeat ($urandom_range(0, 2))
                add_junk(junk_size());
            if ($urandom_range(0, 9) != 0)
                add_fmt(fmt_size(), fmt_code_pick(), HALF_W'($urandom), $urandom,
                        HALF_W'($urandom));
            repeat ($urandom_range(0, 2))
                add_junk(junk_size());
            add_data(data_size());
            repeat ($urandom_range(0, 3))
                add_le($urandom, 1);
            // cut short: the next stream restarts part-way through this one
            if ($urandom_range(0, 9) == 0)
            begin
                cut = $urandom_range(1, wav_bytes.size() - 1);
                while (wav_bytes.size() > cut)
                    void'(wav_bytes.pop_back());
            end
        end
        // now and then no restart, so the stream runs on from the last one
        send_stream($urandom_range(0, 19) != 0);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            random_wav();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Spoilt RIFF tag, then spoilt WAVE tag at its last byte; size bytes
    // are left random since they are not checked
    task automatic test_header_tags();
        add_riff(3);
        add_le(32'h0000_FFFF, 2);
        send_stream(1'b1);
        add_riff(11);
        add_le(32'h55, 1);
        send_stream(1'b1);
    endtask

    // fmt declared too short, non-PCM format, format rejected on high byte
    task automatic test_fmt_rejects();
        add_riff(-1);
        add_fmt(32'd15, FORMAT_PCM, 16'd2, 32'd48000, 16'd16);
        send_stream(1'b1);
        add_riff(-1);
        add_fmt(FMT_MIN_SIZE, 16'h0003, 16'd1, 32'd8000, 16'd32);
        send_stream(1'b1);
        add_riff(-1);
        add_fmt(FMT_MIN_SIZE, 16'h0101, 16'd1, 32'd8000, 16'd8);
        send_stream(1'b1);
    endtask

    // Whole headers: fmt extension, odd chunk with pad, empty chunk,
    // data above, at and just over the limit, bytes after the terminal status
    task automatic test_full_headers();
        add_riff(-1);
        add_fmt(32'd18, FORMAT_PCM, 16'd2, 32'd44100, 16'd16);
        add_junk(32'd3);
        add_junk(32'd0);
        add_data(32'hFFFF_FFFF);
        add_le(32'h00FF_00FF, 3);
        send_stream(1'b1);
        add_riff(-1);
        add_fmt(32'd17, FORMAT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_data(STREAM_LIMIT_RESET);
        send_stream(1'b1);
        add_riff(-1);
        add_data(STREAM_LIMIT_RESET + 1);
        send_stream(1'b1);
    endtask

    // Restart part-way through a fmt body; a restart-free tail after a
    // terminal status must leave everything as it was
    task automatic test_restart();
        add_riff(-1);
        add_fmt(FMT_MIN_SIZE, FORMAT_PCM, 16'd6, 32'd96000, 16'd24);
        while (wav_bytes.size() > 25)
            void'(wav_bytes.pop_back());
        send_stream(1'b1);
        add_riff(-1);
        add_data(32'd100);
        send_stream(1'b1);
        add_le(32'hA5C3_0F81, 4);
        send_stream(1'b0);
    endtask

    // Chunk limit of one: trips after an empty chunk, and after fmt; limit of two: trips after an odd chunk and fmt
    task automatic test_chunk_limit();
        drain_results();
        set_limits(32'd1000, 8'd1);
        add_riff(-1);
        add_junk(32'd0);
        add_data(32'd5);
        send_stream(1'b1);
        add_riff(-1);
        add_fmt(FMT_MIN_SIZE, FORMAT_PCM, 16'd1, 32'd22050, 16'd8);
        add_data(32'd0);
        send_stream(1'b1);
        drain_results();
        set_limits(32'd1000, 8'd2);
        add_riff(-1);
        add_junk(32'd1);
        add_fmt(FMT_MIN_SIZE, FORMAT_PCM, 16'd2, 32'd11025, 16'd16);
        add_data(32'd1001);
        send_stream(1'b1);
    endtask

    // Random streams under a run of limit settings, extremes included;
    // every setting change waits for the parser to empty first
    task automatic test_limit_sweep();
        drain_results();
        set_limits(STREAM_LIMIT_RESET, CHUNK_LIMIT_RESET);
        run_random(250);
        drain_results();
        set_limits(32'd0, 8'd1);
        run_random(150);
        drain_results();
        set_limits(32'hFFFF_FFFF, 8'd255);
        run_random(150);
        drain_results();
        set_limits($urandom_range(0, 64), 8'd3);
        run_random(150);
        drain_results();
        set_limits($urandom, COUNT_W'($urandom_range(2, 6)));
        run_random(100);
        drain_results();
        set_limits(STREAM_LIMIT_RESET, CHUNK_LIMIT_RESET);
        run_random(100);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        stream_ch.valid      <= 1'b0;
        stream_ch.byte_value <= '0;
        stream_ch.restart    <= 1'b0;
        cfg_write_en         <= 1'b0;
        cfg_index            <= REG_STREAM_LIMIT;
        cfg_data             <= '0;
        lim_bytes  = STREAM_LIMIT_RESET;
        lim_chunks = CHUNK_LIMIT_RESET;
        clear_walk();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_tags();
        test_fmt_rejects();
        test_full_headers();
        test_restart();
        test_chunk_limit();
        test_limit_sweep();

        drain_results();
        // two-stage pipe: a short wait after the drain catches any stray beat
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("wav_header_parser_top verification clean");
        else
            $display("wav_header_parser_top verification failed");
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial
    begin
        #4000000;
        $display("wav_header_parser_top verification failed");
        $finish;
    end

endmodule
